@@ rtl/bag_pkg.sv @@
// Shared types and constants for the blit address generator.
`timescale 1ns / 1ps
`default_nettype none
package bag_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int FB_SIZE       = SCREEN_WIDTH * SCREEN_HEIGHT;

    // Widest linear address: (511 + 511) + (255 + 255) * 320 needs 18 bits.
    localparam int ADDR_W = 18;
    localparam int SIDX_W = 17;

    localparam logic       REQ_START = 1'b0;
    localparam logic       REQ_STEP  = 1'b1;

    localparam logic [1:0] MODE_FILL   = 2'd0;
    localparam logic [1:0] MODE_IMAGE  = 2'd1;
    localparam logic [1:0] MODE_GLYPH  = 2'd2;
    localparam logic [1:0] MODE_CANCEL = 2'd3;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd3;

    typedef enum logic [0:0] {
        ST_READY,
        ST_BASE
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic base_mul;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/bag_ctrl.sv @@
// Controller: input handshake and command sequencing.
`timescale 1ns / 1ps
`default_nettype none
module bag_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             req_type,
    input  wire logic [1:0]       draw_mode,
    input  wire logic             out_ready,
    input  wire bag_pkg::status_t status,
    output bag_pkg::cmd_t         cmd
);

    bag_pkg::state_t state_reg;
    bag_pkg::state_t state_next;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bag_pkg::ST_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.base_mul = 1'b0;
        accept       = 1'b0;
        case (state_reg)
            bag_pkg::ST_READY:
            begin
                // take a new transaction when the output slot is free or draining
                in_ready = !status.out_full || out_ready;
                accept   = in_valid && in_ready;
                if (accept && req_type == bag_pkg::REQ_START)
                begin
                    cmd.start = 1'b1;
                    if (draw_mode == bag_pkg::MODE_GLYPH)
                    begin
                        state_next = bag_pkg::ST_BASE;
                    end
                end
                else if (accept && req_type == bag_pkg::REQ_STEP)
                begin
                    cmd.step = status.busy;
                end
            end
            bag_pkg::ST_BASE:
            begin
                // finish the glyph base multiply
                cmd.base_mul = 1'b1;
                state_next   = bag_pkg::ST_READY;
            end
            default:
            begin
                state_next = bag_pkg::ST_READY;
            end
        endcase
    end

    a_base_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bag_pkg::ST_BASE |-> $past(cmd.start))
        else $error("glyph base state entered without a start");

endmodule
`default_nettype wire

@@ rtl/bag_datapath.sv @@
// Datapath: command state, pixel walk, address math and output register.
`timescale 1ns / 1ps
`default_nettype none
module bag_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bag_pkg::cmd_t    cmd,
    output bag_pkg::status_t      status,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [8:0]       cfg_data,
    input  wire logic [1:0]       draw_mode,
    input  wire logic [8:0]       dest_x,
    input  wire logic [7:0]       dest_y,
    input  wire logic [8:0]       rect_width,
    input  wire logic [7:0]       rect_height,
    input  wire logic [8:0]       src_x,
    input  wire logic [7:0]       src_y,
    input  wire logic [7:0]       pixel_value,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [15:0]           dest_address,
    output logic                  write_enable,
    output logic [bag_pkg::SIDX_W-1:0] source_index,
    output logic                  from_source,
    output logic [7:0]            write_value,
    output logic                  last_pixel
);

    // configuration
    logic [8:0] image_width_reg;
    logic [7:0] image_height_reg;
    logic [4:0] glyph_width_reg;
    logic [5:0] glyph_height_reg;

    // command state
    logic        busy_reg,         busy_next;
    logic [1:0]  active_mode_reg,  active_mode_next;
    logic [8:0]  row_start_x_reg,  row_start_x_next;
    logic [9:0]  cur_x_reg,        cur_x_next;
    logic [9:0]  end_x_reg,        end_x_next;
    logic [8:0]  cur_y_reg,        cur_y_next;
    logic [8:0]  end_y_reg,        end_y_next;
    logic [8:0]  src_origin_x_reg, src_origin_x_next;
    logic [7:0]  src_origin_y_reg, src_origin_y_next;
    logic [8:0]  src_col_reg,      src_col_next;
    logic [7:0]  src_row_reg,      src_row_next;
    logic [bag_pkg::SIDX_W-1:0] glyph_base_reg, glyph_base_next;
    logic [7:0]  held_value_reg,   held_value_next;
    logic [4:0]  cell_w_reg,       cell_w_next;
    logic [10:0] cell_area_reg,    cell_area_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] o_addr_reg;
    logic        o_we_reg;
    logic [bag_pkg::SIDX_W-1:0] o_sidx_reg;
    logic        o_from_reg;
    logic [7:0]  o_wval_reg;
    logic        o_last_reg;

    // step math
    logic [8:0]  start_w;
    logic [7:0]  start_h;
    logic [bag_pkg::ADDR_W-1:0] full_addr;
    logic [8:0]  row_mul_w;
    logic [16:0] row_prod;
    logic [17:0] sidx_sum;
    logic [bag_pkg::SIDX_W-1:0] sidx;
    logic        fb_hit;
    logic        from_w;
    logic [7:0]  wval;
    logic        x_at_end;
    logic        last_w;
    logic [8:0]  col_inc;
    logic [7:0]  row_inc;
    logic [18:0] base_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 9'd320;
            image_height_reg <= 8'd200;
            glyph_width_reg  <= 5'd8;
            glyph_height_reg <= 6'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bag_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                bag_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[7:0];
                bag_pkg::CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[4:0];
                bag_pkg::CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // geometry of a starting command
        start_w = (draw_mode == bag_pkg::MODE_GLYPH) ? {4'd0, glyph_width_reg} : rect_width;
        start_h = (draw_mode == bag_pkg::MODE_GLYPH) ? {2'd0, glyph_height_reg} : rect_height;

        full_addr = bag_pkg::ADDR_W'(cur_x_reg)
                  + bag_pkg::ADDR_W'(cur_y_reg) * bag_pkg::ADDR_W'(bag_pkg::SCREEN_WIDTH);
        fb_hit    = full_addr < bag_pkg::ADDR_W'(bag_pkg::FB_SIZE);

        // one shared row multiplier: image stride or latched glyph cell width
        row_mul_w = (active_mode_reg == bag_pkg::MODE_GLYPH) ? {4'd0, cell_w_reg}
                                                             : image_width_reg;
        row_prod  = 17'(src_row_reg * row_mul_w);
        sidx_sum  = {1'b0, row_prod} + {9'd0, src_col_reg};
        sidx      = '0;
        from_w    = 1'b0;
        wval      = held_value_reg;
        case (active_mode_reg)
            bag_pkg::MODE_IMAGE:
            begin
                sidx   = sidx_sum[16:0];
                from_w = 1'b1;
            end
            bag_pkg::MODE_GLYPH:
            begin
                sidx   = sidx_sum[16:0] + glyph_base_reg;
                from_w = 1'b1;
                wval   = 8'd0;
            end
            default: ;
        endcase

        x_at_end = ({1'b0, cur_x_reg} + 11'd1) >= {1'b0, end_x_reg};
        last_w   = x_at_end && (({1'b0, cur_y_reg} + 10'd1) >= {1'b0, end_y_reg});
        col_inc  = src_col_reg + 9'd1;
        row_inc  = src_row_reg + 8'd1;

        base_prod = 19'(cell_area_reg * held_value_reg);

        busy_next         = busy_reg;
        active_mode_next  = active_mode_reg;
        row_start_x_next  = row_start_x_reg;
        cur_x_next        = cur_x_reg;
        end_x_next        = end_x_reg;
        cur_y_next        = cur_y_reg;
        end_y_next        = end_y_reg;
        src_origin_x_next = src_origin_x_reg;
        src_origin_y_next = src_origin_y_reg;
        src_col_next      = src_col_reg;
        src_row_next      = src_row_reg;
        glyph_base_next   = glyph_base_reg;
        held_value_next   = held_value_reg;
        cell_w_next       = cell_w_reg;
        cell_area_next    = cell_area_reg;

        if (cmd.start)
        begin
            busy_next = 1'b0;
            if (draw_mode != bag_pkg::MODE_CANCEL)
            begin
                active_mode_next = draw_mode;
                row_start_x_next = dest_x;
                cur_x_next       = {1'b0, dest_x};
                end_x_next       = {1'b0, dest_x} + {1'b0, start_w};
                cur_y_next       = {1'b0, dest_y};
                end_y_next       = {1'b0, dest_y} + {1'b0, start_h};
                held_value_next  = pixel_value;
                cell_w_next      = glyph_width_reg;
                cell_area_next   = 11'(glyph_width_reg * glyph_height_reg);
                glyph_base_next  = '0;
                if (draw_mode == bag_pkg::MODE_GLYPH)
                begin
                    src_origin_x_next = '0;
                    src_origin_y_next = '0;
                    src_col_next      = '0;
                    src_row_next      = '0;
                end
                else
                begin
                    src_origin_x_next = src_x;
                    src_origin_y_next = src_y;
                    src_col_next      = src_x;
                    src_row_next      = src_y;
                end
                busy_next = (start_w != 9'd0) && (start_h != 8'd0);
            end
        end
        else if (cmd.base_mul)
        begin
            glyph_base_next = base_prod[16:0];
        end
        else if (cmd.step)
        begin
            if (last_w)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cur_x_next   = cur_x_reg + 10'd1;
                src_col_next = col_inc;
                if (active_mode_reg == bag_pkg::MODE_IMAGE && col_inc >= image_width_reg)
                begin
                    src_col_next = src_origin_x_reg;
                end
                if (x_at_end)
                begin
                    // wrap to the next destination row
                    cur_x_next   = {1'b0, row_start_x_reg};
                    cur_y_next   = cur_y_reg + 9'd1;
                    src_col_next = src_origin_x_reg;
                    src_row_next = row_inc;
                    if (active_mode_reg == bag_pkg::MODE_IMAGE
                        && row_inc >= image_height_reg)
                    begin
                        src_row_next = src_origin_y_reg;
                    end
                end
            end
        end

        out_valid_next = cmd.step || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            active_mode_reg  <= bag_pkg::MODE_FILL;
            row_start_x_reg  <= '0;
            cur_x_reg        <= '0;
            end_x_reg        <= '0;
            cur_y_reg        <= '0;
            end_y_reg        <= '0;
            src_origin_x_reg <= '0;
            src_origin_y_reg <= '0;
            src_col_reg      <= '0;
            src_row_reg      <= '0;
            glyph_base_reg   <= '0;
            held_value_reg   <= '0;
            cell_w_reg       <= '0;
            cell_area_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            active_mode_reg  <= active_mode_next;
            row_start_x_reg  <= row_start_x_next;
            cur_x_reg        <= cur_x_next;
            end_x_reg        <= end_x_next;
            cur_y_reg        <= cur_y_next;
            end_y_reg        <= end_y_next;
            src_origin_x_reg <= src_origin_x_next;
            src_origin_y_reg <= src_origin_y_next;
            src_col_reg      <= src_col_next;
            src_row_reg      <= src_row_next;
            glyph_base_reg   <= glyph_base_next;
            held_value_reg   <= held_value_next;
            cell_w_reg       <= cell_w_next;
            cell_area_reg    <= cell_area_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            o_addr_reg <= full_addr[15:0];
            o_we_reg   <= fb_hit;
            o_sidx_reg <= sidx;
            o_from_reg <= from_w;
            o_wval_reg <= wval;
            o_last_reg <= last_w;
        end
    end

    assign status.busy     = busy_reg;
    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign dest_address    = o_addr_reg;
    assign write_enable    = o_we_reg;
    assign source_index    = o_sidx_reg;
    assign from_source     = o_from_reg;
    assign write_value     = o_wval_reg;
    assign last_pixel      = o_last_reg;

    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_x_reg < end_x_reg) && (cur_y_reg < end_y_reg))
        else $error("walk position outside the rectangle while busy");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && last_w |=> !busy_reg)
        else $error("engine still busy after the final pixel");

    a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> busy_reg ##1 out_valid_reg)
        else $error("step taken without a pixel transaction");

endmodule
`default_nettype wire

@@ rtl/blit_address_generator_core.sv @@
// Top level of the blit address generator: stream ports around controller and datapath.
// A step transaction's pixel write is registered and shows in the cycle after acceptance.
// Throughput: one step per cycle while the output register is free or draining.
// A glyph start adds an ST_BASE state for the cell-area times code multiply.
// Reset (rst_n low, asynchronous) idles the engine, empties the output register and
// restores image 320x200 and glyph 8x8.
`timescale 1ns / 1ps
`default_nettype none
module blit_address_generator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // dest_x, dest_y, rect_width, rect_height, src_x, src_y, pixel_value, zero pad
    input  wire logic [63:0] s_tdata,
    // req_type, draw_mode
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // dest_address, source_index, write_value, zero pad
    output logic [47:0]      m_tdata,
    // write_enable, from_source
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    bag_pkg::cmd_t    cmd;
    bag_pkg::status_t status;
    logic [15:0]      dest_address;
    logic             write_enable;
    logic [bag_pkg::SIDX_W-1:0] source_index;
    logic             from_source;
    logic [7:0]       write_value;

    bag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req_type  (s_tuser[0]),
        .draw_mode (s_tuser[2:1]),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bag_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .draw_mode    (s_tuser[2:1]),
        .dest_x       (s_tdata[8:0]),
        .dest_y       (s_tdata[16:9]),
        .rect_width   (s_tdata[25:17]),
        .rect_height  (s_tdata[33:26]),
        .src_x        (s_tdata[42:34]),
        .src_y        (s_tdata[50:43]),
        .pixel_value  (s_tdata[58:51]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .dest_address (dest_address),
        .write_enable (write_enable),
        .source_index (source_index),
        .from_source  (from_source),
        .write_value  (write_value),
        .last_pixel   (m_tlast)
    );

    assign m_tdata = {7'd0, write_value, source_index, dest_address};
    assign m_tuser = {from_source, write_enable};

endmodule
`default_nettype wire
